[rtl/hcr_pkg.sv]
// hcr_pkg: shared widths, register indexes and types of the harris corner response block
// no dependencies; used by hcr_resp and harris_corner_response
package hcr_pkg;

  localparam int PIX_W   = 8;    // gray pixel
  localparam int GX_W    = 11;   // jx and jy, signed
  localparam int GXY_W   = 10;   // jxy, signed
  localparam int GRAD_W  = 32;   // one packed gradient: jx, jy, jxy from the lsb
  localparam int SLOTS   = 5;    // gradient rows held per column
  localparam int SQ_W    = 20;   // jx^2, jy^2
  localparam int CSQ_W   = 23;   // column sum of five squares
  localparam int WSQ_W   = 25;   // window sum sx, sy
  localparam int CXY_W   = 13;   // column sum of five jxy, signed
  localparam int WXY_W   = 15;   // window sum sxy, signed
  localparam int TR_W    = 26;   // sx + sy
  localparam int TR2_W   = 52;   // trace squared
  localparam int PXY_W   = 50;   // sx * sy
  localparam int PC_W    = 28;   // sxy^2
  localparam int DIFF_W  = 51;   // sx*sy - sxy^2, signed
  localparam int RESP_W  = 53;   // response, signed
  localparam int K_W     = 16;   // harris_k
  localparam int DIM_W   = 10;   // frame_cols, frame_rows registers

  localparam logic [1:0] REG_COLS = 2'd0;
  localparam logic [1:0] REG_ROWS = 2'd1;
  localparam logic [1:0] REG_K    = 2'd2;

  typedef struct packed {
    logic [WSQ_W-1:0]        sx;
    logic [WSQ_W-1:0]        sy;
    logic signed [WXY_W-1:0] sxy;
  } hcr_win_t;

endpackage

[rtl/harris_corner_response.sv]
// harris_corner_response: top level, line stores, gradient sweep, frame store and readout
// depends on hcr_pkg, hcr_ram, hcr_resp
//
//  channel   dir  beat content
//  s_axis    in   tuser op (0 push, 1 read), tdata pixel
//  m_axis    out  tdata response/row/col, tlast last pixel, tuser status
//  apb       in   frame_cols @0x0, frame_rows @0x4, harris_k @0x8
//
// the push that ends row r (r >= 1) starts a column sweep over columns 0 to cols, then
// a pipeline drain, two sweeps on the last row
// a read passes through the registered read port of the frame store
// the stores hold no reset state, so there is no clearing pass after reset
// a read result waits in the output register while tready is low; new beats are taken
// only when that register is free or draining
module harris_corner_response #(
  parameter int MAX_COLS        = 512,
  parameter int MAX_ROWS        = 512,
  parameter int K_FRACTION_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] pixel
  input  logic        s_axis_tuser,   // [0] op
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // [52:0] response, [61:53] row, [70:62] col
  output logic        m_axis_tlast,
  output logic        m_axis_tuser,   // [0] status
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import hcr_pkg::*;

  localparam int CW = $clog2(MAX_COLS + 1);        // column count, holds cols itself
  localparam int XW = $clog2(MAX_COLS);            // column index into line stores
  localparam int RW = $clog2(MAX_ROWS + 1);        // row count
  localparam int FD = MAX_ROWS * MAX_COLS;         // frame store depth
  localparam int AW = $clog2(FD);
  localparam int GW = SLOTS * GRAD_W;

  typedef enum logic [1:0] {ST_IDLE, ST_SWEEP, ST_DRAIN, ST_READ} state_e;

  state_e state_q;

  // configuration registers
  logic [DIM_W-1:0] frame_cols_q, frame_rows_q;
  logic [K_W-1:0]   harris_k_q;
  logic [CW-1:0]    cols_c;
  logic [RW-1:0]    rows_c;

  // load and read bookkeeping
  logic [CW-1:0] load_col_q, read_col_q;
  logic [RW-1:0] load_row_q, read_row_q;
  logic [1:0]    pslot_q;
  logic [2:0]    gslot_q;
  logic [AW-1:0] resp_base_q, read_base_q;
  logic          loaded_q;
  logic signed [RESP_W-1:0] max_q;

  // sweep control
  logic [CW-1:0] sw_n_q;
  logic          sw_zero_q, sw_resp_q, sw_b_q;
  logic [1:0]    sw_pslot_q;

  // read path
  logic          rd_in_q, rd_last_q;
  logic [RW-1:0] rd_row_q;
  logic [CW-1:0] rd_col_q;

  // output register
  logic                     ov_q;
  logic signed [RESP_W-1:0] out_resp_q;
  logic [8:0]               out_row_q, out_col_q;
  logic                     out_last_q, out_status_q;

  // handshakes
  logic in_acc, push_acc, cfg_wr, restart, out_free;
  logic [CW-1:0] eff_col;
  logic [RW-1:0] eff_row;
  logic [1:0]    eff_pslot;
  logic          row_end, final_row;

  always_comb begin
    if (frame_cols_q < DIM_W'(5)) begin
      cols_c = CW'(5);
    end else if (32'(frame_cols_q) > 32'(MAX_COLS)) begin
      cols_c = CW'(MAX_COLS);
    end else begin
      cols_c = CW'(frame_cols_q);
    end
    if (frame_rows_q < DIM_W'(5)) begin
      rows_c = RW'(5);
    end else if (32'(frame_rows_q) > 32'(MAX_ROWS)) begin
      rows_c = RW'(MAX_ROWS);
    end else begin
      rows_c = RW'(frame_rows_q);
    end
  end

  assign out_free      = !ov_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE) && out_free;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign push_acc      = in_acc && !s_axis_tuser;
  assign cfg_wr        = psel && penable && pwrite;
  assign restart       = (cfg_wr && (paddr[3:2] == REG_COLS || paddr[3:2] == REG_ROWS))
                       || (push_acc && loaded_q);

  // a push onto a loaded frame starts the next frame at the origin
  assign eff_col   = loaded_q ? '0 : load_col_q;
  assign eff_row   = loaded_q ? '0 : load_row_q;
  assign eff_pslot = loaded_q ? 2'd0 : pslot_q;
  assign row_end   = (eff_col == cols_c - CW'(1));
  assign final_row = (eff_row == rows_c - RW'(1));

  // apb
  assign pready = 1'b1;
  always_comb begin
    unique case (paddr[3:2])
      REG_COLS: prdata = 32'(frame_cols_q);
      REG_ROWS: prdata = 32'(frame_rows_q);
      REG_K:    prdata = 32'(harris_k_q);
      default:  prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // pixel line store: three rows, one ram per row slot
  logic [PIX_W-1:0] pix_rdata [3];
  logic             pix_re;

  assign pix_re = (state_q == ST_SWEEP) && (sw_n_q != cols_c);

  for (genvar i = 0; i < 3; i++) begin : g_pix
    hcr_ram #(.WIDTH(PIX_W), .DEPTH(MAX_COLS)) u_pix (
      .clk_i   (clk_i),
      .we_i    (push_acc && (eff_pslot == 2'(i))),
      .waddr_i (eff_col[XW-1:0]),
      .wdata_i (s_axis_tdata),
      .re_i    (pix_re),
      .raddr_i (sw_n_q[XW-1:0]),
      .rdata_o (pix_rdata[i])
    );
  end

  // ---------------------------------------------------------------------------
  // gradient line store: five gradient rows packed per column, read-modify-write
  logic          grad_re, grad_we;
  logic [CW-1:0] grad_raddr;
  logic [GW-1:0] grad_rdata;

  // pipeline stage registers
  logic          p1_v_q, p2_v_q, p3_v_q, p4_v_q, win_v_q;
  logic [CW-1:0] p1_n_q, p2_g_q, p3_g_q, p4_g_q, win_col_q;
  logic [GW-1:0] p2_word_q;
  logic signed [8:0] s1_q, s2_q;
  logic [9:0]        t1_q, t2_q;
  logic [SQ_W-1:0]  sqx_q [SLOTS];
  logic [SQ_W-1:0]  sqy_q [SLOTS];
  logic signed [GXY_W-1:0] jxy_q [SLOTS];
  logic [CSQ_W-1:0] tap_x_q [SLOTS];
  logic [CSQ_W-1:0] tap_y_q [SLOTS];
  logic signed [CXY_W-1:0] tap_xy_q [SLOTS];
  hcr_win_t win_q;

  assign grad_re    = (state_q == ST_SWEEP) && (sw_n_q != '0);
  assign grad_raddr = sw_n_q - CW'(1);
  assign grad_we    = p2_v_q;

  hcr_ram #(.WIDTH(GW), .DEPTH(MAX_COLS)) u_grad (
    .clk_i   (clk_i),
    .we_i    (grad_we),
    .waddr_i (p2_g_q[XW-1:0]),
    .wdata_i (p2_word_q),
    .re_i    (grad_re),
    .raddr_i (grad_raddr[XW-1:0]),
    .rdata_o (grad_rdata)
  );

  // stage 1: pixel column n arrives, gradient of column n-1 forms
  logic [1:0]  sl_a, sl_b;
  logic [PIX_W-1:0] pa, pb, pc;
  logic signed [8:0]  s_n;
  logic [9:0]         t_n;
  logic signed [GX_W-1:0]  jx, jy;
  logic signed [GXY_W-1:0] jxy;
  logic [CW-1:0] g1;
  logic          gz;
  logic [GW-1:0] merged;

  always_comb begin
    unique case (sw_pslot_q)
      2'd0:    begin sl_b = 2'd2; sl_a = 2'd1; end
      2'd1:    begin sl_b = 2'd0; sl_a = 2'd2; end
      default: begin sl_b = 2'd1; sl_a = 2'd0; end
    endcase
    pa  = pix_rdata[sl_a];
    pb  = pix_rdata[sl_b];
    pc  = pix_rdata[sw_pslot_q];
    s_n = $signed({1'b0, pa}) - $signed({1'b0, pc});
    t_n = {2'b0, pa} + {1'b0, pb, 1'b0} + {2'b0, pc};
    jx  = $signed({{2{s2_q[8]}}, s2_q}) + $signed({s1_q[8], s1_q, 1'b0})
        + $signed({{2{s_n[8]}}, s_n});
    jy  = $signed({1'b0, t2_q}) - $signed({1'b0, t_n});
    jxy = $signed({s2_q[8], s2_q}) - $signed({s_n[8], s_n});
    g1  = p1_n_q - CW'(1);
    // border columns, the first gradient row and the closing row are zero
    gz  = sw_zero_q || (g1 == '0) || (g1 == cols_c - CW'(1));
    merged = grad_rdata;
    merged[int'(gslot_q) * GRAD_W +: GRAD_W] = gz ? '0 : {jxy, jy, jx};
  end

  // stage 2: squares of every slot
  logic signed [2*GX_W-1:0] px [SLOTS];
  logic signed [2*GX_W-1:0] py [SLOTS];
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      px[i] = $signed(p2_word_q[i*GRAD_W +: GX_W]) * $signed(p2_word_q[i*GRAD_W +: GX_W]);
      py[i] = $signed(p2_word_q[i*GRAD_W+GX_W +: GX_W])
            * $signed(p2_word_q[i*GRAD_W+GX_W +: GX_W]);
    end
  end

  // stage 3: column sums; stage 4: window sums over five column taps
  logic [CSQ_W-1:0] cx, cy;
  logic signed [CXY_W-1:0] cxy;
  logic [WSQ_W-1:0] wx, wy;
  logic signed [WXY_W-1:0] wxy;
  always_comb begin
    cx  = '0;
    cy  = '0;
    cxy = '0;
    wx  = '0;
    wy  = '0;
    wxy = '0;
    for (int i = 0; i < SLOTS; i++) begin
      cx  = cx + CSQ_W'(sqx_q[i]);
      cy  = cy + CSQ_W'(sqy_q[i]);
      cxy = cxy + $signed({{(CXY_W-GXY_W){jxy_q[i][GXY_W-1]}}, jxy_q[i]});
      wx  = wx + WSQ_W'(tap_x_q[i]);
      wy  = wy + WSQ_W'(tap_y_q[i]);
      wxy = wxy + $signed({{(WXY_W-CXY_W){tap_xy_q[i][CXY_W-1]}}, tap_xy_q[i]});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_v_q  <= 1'b0;
      p2_v_q  <= 1'b0;
      p3_v_q  <= 1'b0;
      p4_v_q  <= 1'b0;
      win_v_q <= 1'b0;
    end else begin
      p1_v_q  <= (state_q == ST_SWEEP);
      p2_v_q  <= p1_v_q && (p1_n_q != '0);
      p3_v_q  <= p2_v_q;
      p4_v_q  <= p3_v_q;
      // interior window centers only
      win_v_q <= p4_v_q && (p4_g_q >= CW'(4)) && sw_resp_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p1_n_q <= sw_n_q;
    if (p1_v_q) begin
      s1_q <= s_n;
      s2_q <= s1_q;
      t1_q <= t_n;
      t2_q <= t1_q;
    end
    p2_word_q <= merged;
    p2_g_q    <= g1;
    for (int i = 0; i < SLOTS; i++) begin
      sqx_q[i] <= px[i][SQ_W-1:0];
      sqy_q[i] <= py[i][SQ_W-1:0];
      jxy_q[i] <= $signed(p2_word_q[i*GRAD_W+2*GX_W +: GXY_W]);
    end
    p3_g_q <= p2_g_q;
    if (p3_v_q) begin
      tap_x_q[0]  <= cx;
      tap_y_q[0]  <= cy;
      tap_xy_q[0] <= cxy;
      for (int i = 1; i < SLOTS; i++) begin
        tap_x_q[i]  <= tap_x_q[i-1];
        tap_y_q[i]  <= tap_y_q[i-1];
        tap_xy_q[i] <= tap_xy_q[i-1];
      end
    end
    p4_g_q     <= p3_g_q;
    win_q.sx   <= wx;
    win_q.sy   <= wy;
    win_q.sxy  <= wxy;
    win_col_q  <= p4_g_q - CW'(2);
  end

  // ---------------------------------------------------------------------------
  // response arithmetic
  logic                     rv;
  logic signed [RESP_W-1:0] rr;
  logic [CW-1:0]            rcol;
  logic                     resp_busy;
  logic                     pipe_busy;

  hcr_resp #(.KF(K_FRACTION_BITS), .COL_W(CW)) u_resp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .win_valid_i (win_v_q),
    .win_i       (win_q),
    .col_i       (win_col_q),
    .k_i         (harris_k_q),
    .valid_o     (rv),
    .resp_o      (rr),
    .col_o       (rcol),
    .busy_o      (resp_busy)
  );

  assign pipe_busy = p1_v_q | p2_v_q | p3_v_q | p4_v_q | win_v_q | resp_busy;

  // ---------------------------------------------------------------------------
  // frame store of responses, row-major at MAX_COLS pitch
  logic                     fr_re;
  logic [RESP_W-1:0]        fr_rdata;

  assign fr_re = in_acc && s_axis_tuser && loaded_q;

  hcr_ram #(.WIDTH(RESP_W), .DEPTH(FD)) u_frame (
    .clk_i   (clk_i),
    .we_i    (rv),
    .waddr_i (resp_base_q + AW'(rcol)),
    .wdata_i (rr),
    .re_i    (fr_re),
    .raddr_i (read_base_q + AW'(read_col_q)),
    .rdata_o (fr_rdata)
  );

  // thresholding against the frame maximum
  logic signed [RESP_W-1:0] rd_v;
  logic signed [RESP_W+6:0] rd_v100;
  logic signed [RESP_W-1:0] rd_out;
  logic                     rd_inside;

  always_comb begin
    rd_v    = rd_in_q ? $signed(fr_rdata) : '0;
    rd_v100 = $signed({{7{rd_v[RESP_W-1]}}, rd_v}) * $signed(60'sd100);
    rd_out  = (rd_v100 <= $signed({7'b0, max_q})) ? '0 : rd_v;
    rd_inside = (read_row_q >= RW'(2))
             && (({1'b0, read_row_q} + (RW+1)'(2)) < {1'b0, rows_c})
             && (read_col_q >= CW'(2))
             && (({1'b0, read_col_q} + (CW+1)'(2)) < {1'b0, cols_c});
  end

  // ---------------------------------------------------------------------------
  // control, configuration and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      frame_cols_q <= DIM_W'(512);
      frame_rows_q <= DIM_W'(512);
      harris_k_q   <= K_W'(4588);
      load_row_q   <= '0;
      load_col_q   <= '0;
      read_row_q   <= '0;
      read_col_q   <= '0;
      read_base_q  <= '0;
      resp_base_q  <= AW'(2 * MAX_COLS);
      pslot_q      <= '0;
      gslot_q      <= '0;
      loaded_q     <= 1'b0;
      max_q        <= '0;
      sw_n_q       <= '0;
      sw_zero_q    <= 1'b0;
      sw_resp_q    <= 1'b0;
      sw_b_q       <= 1'b0;
      sw_pslot_q   <= '0;
      rd_in_q      <= 1'b0;
      rd_last_q    <= 1'b0;
      rd_row_q     <= '0;
      rd_col_q     <= '0;
      ov_q         <= 1'b0;
      out_resp_q   <= '0;
      out_row_q    <= '0;
      out_col_q    <= '0;
      out_last_q   <= 1'b0;
      out_status_q <= 1'b0;
    end else begin
      if (m_axis_tready) begin
        ov_q <= 1'b0;
      end

      // running maximum over written responses
      if (rv && (rr > max_q)) begin
        max_q <= rr;
      end

      if (cfg_wr) begin
        unique case (paddr[3:2])
          REG_COLS: frame_cols_q <= pwdata[DIM_W-1:0];
          REG_ROWS: frame_rows_q <= pwdata[DIM_W-1:0];
          REG_K:    harris_k_q   <= pwdata[K_W-1:0];
          default:  ;
        endcase
      end

      if (restart) begin
        load_row_q  <= '0;
        load_col_q  <= '0;
        read_row_q  <= '0;
        read_col_q  <= '0;
        read_base_q <= '0;
        resp_base_q <= AW'(2 * MAX_COLS);
        pslot_q     <= '0;
        gslot_q     <= '0;
        loaded_q    <= 1'b0;
        max_q       <= '0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (push_acc) begin
            if (row_end) begin
              load_col_q <= '0;
              pslot_q    <= (eff_pslot == 2'd2) ? 2'd0 : eff_pslot + 2'd1;
              if (final_row) begin
                load_row_q <= '0;
                loaded_q   <= 1'b1;
              end else begin
                load_row_q <= eff_row + RW'(1);
              end
              // gradient row r-1, and its response row once five rows exist
              if (eff_row != '0) begin
                state_q    <= ST_SWEEP;
                sw_n_q     <= '0;
                sw_zero_q  <= (eff_row == RW'(1));
                sw_resp_q  <= (eff_row >= RW'(5));
                sw_b_q     <= final_row;
                sw_pslot_q <= eff_pslot;
              end
            end else begin
              load_col_q <= eff_col + CW'(1);
            end
          end else if (in_acc && !loaded_q) begin
            // read before the frame is complete
            ov_q         <= 1'b1;
            out_resp_q   <= '0;
            out_row_q    <= '0;
            out_col_q    <= '0;
            out_last_q   <= 1'b0;
            out_status_q <= 1'b1;
          end else if (in_acc) begin
            state_q   <= ST_READ;
            rd_in_q   <= rd_inside;
            rd_row_q  <= read_row_q;
            rd_col_q  <= read_col_q;
            rd_last_q <= (read_row_q == rows_c - RW'(1)) && (read_col_q == cols_c - CW'(1));
            if (read_col_q != cols_c - CW'(1)) begin
              read_col_q <= read_col_q + CW'(1);
            end else begin
              read_col_q <= '0;
              if (read_row_q != rows_c - RW'(1)) begin
                read_row_q  <= read_row_q + RW'(1);
                read_base_q <= read_base_q + AW'(MAX_COLS);
              end else begin
                read_row_q  <= '0;
                read_base_q <= '0;
              end
            end
          end
        end
        ST_SWEEP: begin
          sw_n_q <= sw_n_q + CW'(1);
          if (sw_n_q == cols_c) begin
            state_q <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (!pipe_busy) begin
            gslot_q <= (gslot_q == 3'd4) ? 3'd0 : gslot_q + 3'd1;
            if (sw_resp_q) begin
              resp_base_q <= resp_base_q + AW'(MAX_COLS);
            end
            // the last row also closes with an all-zero gradient row
            if (sw_b_q) begin
              state_q   <= ST_SWEEP;
              sw_n_q    <= '0;
              sw_zero_q <= 1'b1;
              sw_resp_q <= 1'b1;
              sw_b_q    <= 1'b0;
            end else begin
              state_q <= ST_IDLE;
            end
          end
        end
        ST_READ: begin
          if (out_free) begin
            state_q      <= ST_IDLE;
            ov_q         <= 1'b1;
            out_resp_q   <= rd_out;
            out_row_q    <= 9'(rd_row_q);
            out_col_q    <= 9'(rd_col_q);
            out_last_q   <= rd_last_q;
            out_status_q <= 1'b0;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = {1'b0, out_col_q, out_row_q, out_resp_q};
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_status_q;

endmodule

[rtl/hcr_ram.sv]
// hcr_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
module hcr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/hcr_resp.sv]
// hcr_resp: five-stage pipeline from window sums to the saturated harris response
// depends on hcr_pkg
module hcr_resp #(
  parameter int KF    = 16,
  parameter int COL_W = 10
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          win_valid_i,
  input  hcr_pkg::hcr_win_t             win_i,
  input  logic [COL_W-1:0]              col_i,
  input  logic [hcr_pkg::K_W-1:0]       k_i,
  output logic                          valid_o,
  output logic signed [hcr_pkg::RESP_W-1:0] resp_o,
  output logic [COL_W-1:0]              col_o,
  output logic                          busy_o
);
  import hcr_pkg::*;

  localparam int HKW = TR2_W - KF + K_W;
  localparam int KTW = HKW + 1;
  localparam int IW  = (((HKW + 2) > DIFF_W) ? (HKW + 2) : DIFF_W) + 1;

  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic [COL_W-1:0] c1_q, c2_q, c3_q, c4_q, c5_q;
  logic [PXY_W-1:0] pxy_q;
  logic [PC_W-1:0]  pc_q;
  logic [TR_W-1:0]  tr_q;
  logic [TR2_W-1:0] tr2_q;
  logic signed [DIFF_W-1:0] diff2_q, diff3_q, diff4_q;
  logic [HKW-1:0]   hk_q;
  logic [KF+K_W-1:0] lk_q;
  logic [KTW-1:0]   kterm_q;
  logic signed [RESP_W-1:0] resp_q;

  logic signed [2*WXY_W-1:0] sxy_sq;
  logic signed [IW-1:0] r_full;
  logic [IW-RESP_W:0]   r_top;
  logic signed [RESP_W-1:0] r_sat;

  assign sxy_sq = win_i.sxy * win_i.sxy;

  always_comb begin
    r_full = $signed({{(IW-DIFF_W){diff4_q[DIFF_W-1]}}, diff4_q})
           - $signed({{(IW-KTW){1'b0}}, kterm_q});
    r_top  = r_full[IW-1:RESP_W-1];
    if ((&r_top) || !(|r_top)) begin
      r_sat = r_full[RESP_W-1:0];
    end else if (r_full[IW-1]) begin
      r_sat = {1'b1, {(RESP_W-1){1'b0}}};
    end else begin
      r_sat = {1'b0, {(RESP_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      v1_q <= win_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    pxy_q   <= win_i.sx * win_i.sy;
    pc_q    <= sxy_sq[PC_W-1:0];
    tr_q    <= win_i.sx + win_i.sy;
    c1_q    <= col_i;
    tr2_q   <= tr_q * tr_q;
    diff2_q <= $signed({1'b0, pxy_q}) - $signed({{(DIFF_W-PC_W){1'b0}}, pc_q});
    c2_q    <= c1_q;
    hk_q    <= tr2_q[TR2_W-1:KF] * k_i;
    lk_q    <= tr2_q[KF-1:0] * k_i;
    diff3_q <= diff2_q;
    c3_q    <= c2_q;
    kterm_q <= {1'b0, hk_q} + KTW'(lk_q[KF+K_W-1:KF]);
    diff4_q <= diff3_q;
    c4_q    <= c3_q;
    resp_q  <= r_sat;
    c5_q    <= c4_q;
  end

  assign valid_o = v5_q;
  assign resp_o  = resp_q;
  assign col_o   = c5_q;
  assign busy_o  = v1_q | v2_q | v3_q | v4_q | v5_q;

endmodule
